/* sv/b64lw_pkg.sv */
// Shared types, constants and the symbol table for the line-wrapping Base64 encoder.
`default_nettype none
package b64lw_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueueAw    = $clog2(QueueDepth);

    localparam logic [7:0] GroupsPerLineReset = 8'd19;
    localparam logic [7:0] CharPad = 8'h3D;  // '='
    localparam logic [7:0] CharCr  = 8'h0D;
    localparam logic [7:0] CharLf  = 8'h0A;

    // Position of the next byte in its 3-byte group.
    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } t_phase;

    // One classified input byte: up to four characters, last holds count minus one.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last;
    } t_entry;

    function automatic logic [7:0] sym(input logic [5:0] six);
        logic [7:0] r;
        if (six < 6'd26) begin
            r = 8'h41 + {2'b00, six};
        end else if (six < 6'd52) begin
            r = 8'h61 + {2'b00, six} - 8'd26;
        end else if (six < 6'd62) begin
            r = 8'h30 + {2'b00, six} - 8'd52;
        end else if (six == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/b64lw_front.sv */
// Front end: accepts bytes, tracks group and line state, forms character entries.
`default_nettype none
module b64lw_front
    import b64lw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_valid,
    input  wire logic   [7:0] i_cfg_data,
    input  wire logic   i_valid,
    input  wire logic   [7:0] i_data_byte,
    input  wire logic   i_final_byte,
    input  wire logic   i_q_full,
    output logic        o_ready,
    output logic        o_push,
    output t_entry      o_entry
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_left, n_left;
    logic [7:0] r_lines, n_lines;
    logic [7:0] r_gpl;
    logic       accept;
    logic [8:0] lines_inc;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && !i_q_full;
    assign o_push    = accept;
    assign lines_inc = {1'b0, r_lines} + 9'd1;

    always_comb begin
        o_entry = '0;
        n_phase = r_phase;
        n_left  = r_left;
        n_lines = r_lines;
        case (r_phase)
            PH_SECOND: begin
                o_entry.chars[0] = sym({r_left[1:0], i_data_byte[7:4]});
                n_left  = i_data_byte[3:0];
                n_phase = PH_THIRD;
                if (i_final_byte) begin
                    o_entry.chars[1] = sym({i_data_byte[3:0], 2'b00});
                    o_entry.chars[2] = CharPad;
                    o_entry.last     = 2'd2;
                end
            end
            PH_THIRD: begin
                o_entry.chars[0] = sym({r_left, i_data_byte[7:6]});
                o_entry.chars[1] = sym(i_data_byte[5:0]);
                o_entry.last     = 2'd1;
                n_left  = 4'd0;
                n_phase = PH_FIRST;
                if (r_gpl == 8'd0) begin
                    n_lines = 8'd0;
                end else if (lines_inc >= {1'b0, r_gpl}) begin
                    o_entry.chars[2] = CharCr;
                    o_entry.chars[3] = CharLf;
                    o_entry.last     = 2'd3;
                    n_lines = 8'd0;
                end else begin
                    n_lines = lines_inc[7:0];
                end
            end
            default: begin
                o_entry.chars[0] = sym(i_data_byte[7:2]);
                n_left  = {2'b00, i_data_byte[1:0]};
                n_phase = PH_SECOND;
                if (i_final_byte) begin
                    o_entry.chars[1] = sym({i_data_byte[1:0], 4'b0000});
                    o_entry.chars[2] = CharPad;
                    o_entry.chars[3] = CharPad;
                    o_entry.last     = 2'd3;
                end
            end
        endcase
        if (i_final_byte) begin
            n_phase = PH_FIRST;
            n_left  = 4'd0;
            n_lines = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_left  <= 4'd0;
            r_lines <= 8'd0;
            r_gpl   <= GroupsPerLineReset;
        end else begin
            if (i_cfg_valid) begin
                r_gpl <= i_cfg_data;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_lines <= n_lines;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/b64lw_queue.sv */
// Short queue of character entries between front and back end.
`default_nettype none
module b64lw_queue
    import b64lw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_entry
);

    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    t_entry              r_mem [QueueDepth];
    logic [QueueAw-1:0]  r_wr, r_rd;
    logic [CntW-1:0]     r_cnt;

    assign o_full  = (r_cnt == CntW'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QueueAw'(QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QueueAw'(QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(QueueDepth))
        else $error("queue count out of range");
    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty)
        else $error("queue empty after push");
`endif

endmodule
`default_nettype wire

/* sv/b64lw_back.sv */
// Back end: walks each entry's characters out one per cycle while i_tready is high.
`default_nettype none
module b64lw_back
    import b64lw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_empty,
    input  wire t_entry i_entry,
    output logic        o_pop,
    input  wire logic   i_tready,
    output logic        o_tvalid,
    output logic [7:0]  o_tdata,
    output logic        o_tlast
);

    t_entry     r_cur;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       done;

    assign o_tvalid = r_valid;
    assign o_tdata  = r_cur.chars[r_idx];
    assign o_tlast  = (r_idx == r_cur.last);
    assign done     = r_valid && i_tready && o_tlast;
    assign o_pop    = !i_q_empty && (!r_valid || done);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (r_valid && i_tready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_cur.last))
        else $error("character index past entry end");
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> (r_idx == 2'd0))
        else $error("index not cleared while idle");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_tready) |=> (r_valid && $stable(r_idx)))
        else $error("character moved while stalled");
`endif

endmodule
`default_nettype wire

/* sv/base64_encoder_line_wrap.sv */
// Top level of the streaming Base64 encoder with CR LF line wrapping.
// Usage:
//   s_axis carries one raw byte per request (tdata) and tlast on the final
//   byte of a message. m_axis returns ASCII characters (tdata), with tlast
//   on the last character produced by each input byte (1 to 4 characters).
//   The cfg channel writes groups_per_line (full groups per line, 0 turns
//   wrapping off); it is always ready and should be written while idle.
// Path: with the back end idle, an accepted byte's entry is written into the
//   queue, then loaded into the back-end register, where its first character is valid.
// Throughput: the back end sends one character per cycle while m_axis_tready is
//   high, and each byte yields 1 to 4 characters; the front end
//   takes a byte every cycle while the queue has room.
// Reset: clears group phase, leftover bits, line count and the queue;
//   groups_per_line returns to 19.
// Stall: when m_axis_tready is low the current character holds, the queue
//   fills and s_axis_tready drops once both entries are taken.
`default_nettype none
module base64_encoder_line_wrap
    import b64lw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,      // groups_per_line
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  wire logic        s_axis_tlast,    // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,    // [7:0] out_char
    output logic             m_axis_tlast     // out_last
);

    t_entry push_entry, head_entry;
    logic   push, pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    b64lw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .i_data_byte  (s_axis_tdata),
        .i_final_byte (s_axis_tlast),
        .i_q_full     (q_full),
        .o_ready      (s_axis_tready),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    b64lw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (head_entry)
    );

    b64lw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .i_tready  (m_axis_tready),
        .o_tvalid  (m_axis_tvalid),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the line-wrapping Base64 encoder: byte stream in, ASCII out.
`default_nettype none

module testbench
    import b64lw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    class b64_char_checker;
        string       alphabet =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        logic [7:0]  line_len;
        t_phase      phase;
        logic [3:0]  carry;
        logic [7:0]  line_groups;
        t_enc_char   expected_chars[$];
        int          errors;
        int          bytes_seen;
        int          chars_seen;
        int          breaks_seen;
        int          messages_seen;

        function new();
            line_len      = GroupsPerLineReset;
            phase         = PH_FIRST;
            carry         = '0;
            line_groups   = '0;
            errors        = 0;
            bytes_seen    = 0;
            chars_seen    = 0;
            breaks_seen   = 0;
            messages_seen = 0;
        endfunction

        function void set_line_length(input logic [7:0] groups);
            line_len = groups;
        endfunction

        function logic [7:0] to_symbol(input logic [5:0] six);
            return alphabet[six];
        endfunction

        // Work out the characters one accepted byte produces and queue them.
        function void note_byte(input logic [7:0] b, input logic fin);
            logic [7:0] chars [4];
            int         n;
            t_enc_char  e;
            n = 0;
            case (phase)
                PH_SECOND: begin
                    chars[n] = to_symbol({carry[1:0], b[7:4]});
                    n = n + 1;
                    carry = b[3:0];
                    phase = PH_THIRD;
                    if (fin) begin
                        chars[n] = to_symbol({b[3:0], 2'b00});
                        chars[n + 1] = CharPad;
                        n = n + 2;
                    end
                end
                PH_THIRD: begin
                    chars[0] = to_symbol({carry, b[7:6]});
                    chars[1] = to_symbol(b[5:0]);
                    n = 2;
                    carry = '0;
                    phase = PH_FIRST;
                    if (line_len != 8'd0) begin
                        if ({1'b0, line_groups} + 9'd1 >= {1'b0, line_len}) begin
                            chars[2] = CharCr;
                            chars[3] = CharLf;
                            n = 4;
                            line_groups = '0;
                            breaks_seen++;
                        end else begin
                            line_groups = line_groups + 8'd1;
                        end
                    end else begin
                        line_groups = '0;
                    end
                end
                default: begin
                    chars[0] = to_symbol(b[7:2]);
                    n = 1;
                    carry = {2'b00, b[1:0]};
                    phase = PH_SECOND;
                    if (fin) begin
                        chars[1] = to_symbol({b[1:0], 4'b0000});
                        chars[2] = CharPad;
                        chars[3] = CharPad;
                        n = 4;
                    end
                end
            endcase
            if (fin) begin
                phase       = PH_FIRST;
                carry       = '0;
                line_groups = '0;
                messages_seen++;
            end
            for (int i = 0; i < n; i++) begin
                e.ch   = chars[i];
                e.last = (i == n - 1);
                expected_chars.insert(expected_chars.size(), e);
            end
            bytes_seen++;
        endfunction

        function void check_char(input logic [7:0] ch, input logic last);
            t_enc_char e;
            chars_seen++;
            if (expected_chars.size() == 0) begin
                $error("unexpected character %h (last %0b) with nothing pending", ch, last);
                errors++;
                return;
            end
            e = expected_chars.pop_front();
            if (ch !== e.ch) begin
                $error("out_char mismatch: expected %h, actual %h", e.ch, ch);
                errors++;
            end
            if (last !== e.last) begin
                $error("out_last mismatch: expected %0b, actual %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int CycleLimit = 200000;
    localparam int NumPhases  = 6;
    localparam int PhaseItems = 48;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    int tx_idle_pct;
    int rx_idle_pct;
    int cycle_count;
    int msg_left;

    b64_char_checker enc_check;

    base64_encoder_line_wrap u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            enc_check.check_char(m_axis_tdata, m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        bit gap;
        gap = 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            if (!gap) s_axis_tvalid <= 1'b0;
            gap = 1'b1;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        enc_check.note_byte(b, fin);
    endtask

    // Hold the sender off until every pending character is out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (enc_check.expected_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_line_length(input logic [7:0] groups);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= groups;
        do @(posedge i_clk); while (!o_cfg_ready);
        enc_check.set_line_length(groups);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random message content; lengths mostly short, now and then long enough to wrap.
    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (msg_left == 0) begin
                msg_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
            end
            send_byte(8'($urandom_range(255)), msg_left == 1);
            msg_left--;
        end
    endtask

    initial begin
        logic [7:0] line_choice [NumPhases];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cycle_count   = 0;
        msg_left      = 0;
        tx_idle_pct   = 38;
        rx_idle_pct   = 38;
        enc_check     = new();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Final byte at each group position, extreme byte values, reset line length.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        // One group per line: a final full group still ends with CR LF.
        write_line_length(8'd1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        drain();

        // Shorter line length mid-line wraps at the next full group.
        write_line_length(8'd19);
        for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(255)), 1'b0);
        drain();
        write_line_length(8'd1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        drain();

        // Wrapping off.
        write_line_length(8'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hAA, 1'b1);
        drain();

        line_choice[0] = 8'd19;
        line_choice[1] = 8'd0;
        line_choice[2] = 8'($urandom_range(2, 6));
        line_choice[3] = 8'd1;
        line_choice[4] = 8'd255;
        line_choice[5] = 8'($urandom_range(255));
        for (int p = 0; p < NumPhases; p++) begin
            tx_idle_pct = (p == 2) ? 0 : 38;
            rx_idle_pct = (p == 2) ? 0 : 38;
            write_line_length(line_choice[p]);
            send_random(PhaseItems);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (enc_check.expected_chars.size() != 0) begin
            $error("%0d expected characters never arrived", enc_check.expected_chars.size());
            enc_check.errors++;
        end
        $display("Encoded %0d bytes in %0d messages into %0d characters, %0d line breaks,",
                 enc_check.bytes_seen, enc_check.messages_seen, enc_check.chars_seen,
                 enc_check.breaks_seen);
        $display("line lengths 0, 1, 19, 255 and random, with and without back-pressure.");
        if (enc_check.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* filelist.f */
sv/b64lw_pkg.sv
sv/b64lw_front.sv
sv/b64lw_queue.sv
sv/b64lw_back.sv
sv/base64_encoder_line_wrap.sv
sim/testbench.sv
